@@ hdl/thp_pkg.sv @@
// thp_pkg: shared types and constants for the sensor compensation block
// used by thp_div and thp_sensor_compensation_top; depends on nothing
package thp_pkg;

    localparam int DIV_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM        = 3'd4;

    localparam logic signed [32:0] TF_PRESS_OFS = 33'sd128000;
    localparam logic signed [31:0] TF_HUM_OFS   = 32'sd76800;
    localparam logic [63:0]        PRESS_BIAS   = 64'h0000_8000_0000_0000;
    localparam logic [20:0]        PRESS_RAW_TOP = 21'h100000;
    localparam logic [11:0]        PRESS_SCALE  = 12'd3125;
    localparam logic [31:0]        HUM_CLAMP    = 32'd419430400;
    localparam logic [16:0]        HUM_OUT_MAX  = 17'd102400;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        zero;
    } t_div_side;

endpackage

@@ hdl/thp_div.sv @@
// thp_div: pipelined unsigned 64-bit restoring divider, one quotient bit per stage
// carries a sideband struct alongside each item; depends on thp_pkg
module thp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [thp_pkg::DIV_W-1:0]    i_num,
    input  logic [thp_pkg::DIV_W-1:0]    i_den,
    input  thp_pkg::t_div_side           i_side,
    output logic                         o_valid,
    output logic [thp_pkg::DIV_W-1:0]    o_quo,
    output thp_pkg::t_div_side           o_side
);
    localparam int W = thp_pkg::DIV_W;

    logic [W-1:0]       r_rem  [W];
    logic [W-1:0]       r_quo  [W];
    logic [W-1:0]       r_den  [W];
    thp_pkg::t_div_side r_side [W];
    logic [W-1:0]       r_vld;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]       w_rem_in;
        logic [W-1:0]       w_quo_in;
        logic [W-1:0]       w_den_in;
        thp_pkg::t_div_side w_side_in;
        logic               w_vld_in;
        logic [W:0]         w_sh;
        logic [W+1:0]       w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_quo_in  = i_num;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_sh   = {w_rem_in, w_quo_in[W-1]};
        assign w_diff = {1'b0, w_sh} - {2'b00, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_diff[W+1] ? w_sh[W-1:0] : w_diff[W-1:0];
                r_quo[k]  <= {w_quo_in[W-2:0], ~w_diff[W+1]};
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_side  = r_side[W-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[W-1] && r_den[W-1] != '0) |-> (r_rem[W-1] < r_den[W-1]))
        else $error("divider remainder not below divisor");

    a_hold_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_vld) && $stable(o_quo)))
        else $error("divider moved while disabled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("divider valid bits not cleared by reset");

endmodule

@@ hdl/thp_sensor_compensation_top.sv @@
// thp_sensor_compensation_top: temperature, pressure and humidity compensation
// top level of the pipelined datapath; depends on thp_pkg and thp_div
//
// usage:
//   input channel: i_valid / o_stall with the raw temperature, pressure and
//   humidity words; a transfer happens when i_valid is high and o_stall low
//   output channel: o_valid / i_stall with the compensated temperature,
//   pressure and humidity; a transfer happens when o_valid is high and i_stall low
//   calibration registers are written over i_cfg_we / i_cfg_index / i_cfg_wdata
//   by the user only while no item is in flight, which the block does not enforce;
//   indexes above the last register are ignored
// pipeline: 16 arithmetic stages, 64 divider stages (one quotient bit each),
//   4 post divide stages and the output register
// throughput: one item per cycle unless stalled; fully pipelined 64-bit divider
// reset: synchronous active-low; clears all valid bits and the calibration
//   registers to zero
// stall: when the output register holds an item and i_stall is high the whole
//   pipeline freezes and o_stall is raised in the same cycle; nothing is lost
module thp_sensor_compensation_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [thp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [thp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [19:0]                        i_raw_temperature,
    input  logic [19:0]                        i_raw_pressure,
    input  logic [15:0]                        i_raw_humidity,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [31:0]                 o_temperature_centi,
    output logic [31:0]                        o_pressure_q24_8,
    output logic [16:0]                        o_humidity_q22_10
);
    typedef struct packed {
        logic [63:0] an;
        logic [63:0] ad;
        logic        neg;
        logic        zero;
    } t_press_div;

    // calibration registers
    logic [47:0] r_cfg_temp;
    logic [63:0] r_cfg_plo;
    logic [63:0] r_cfg_pmid;
    logic [15:0] r_cfg_phi;
    logic [63:0] r_cfg_hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp <= '0;
            r_cfg_plo  <= '0;
            r_cfg_pmid <= '0;
            r_cfg_phi  <= '0;
            r_cfg_hum  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                thp_pkg::CFG_TEMP:       r_cfg_temp <= i_cfg_wdata[47:0];
                thp_pkg::CFG_PRESS_LOW:  r_cfg_plo  <= i_cfg_wdata;
                thp_pkg::CFG_PRESS_MID:  r_cfg_pmid <= i_cfg_wdata;
                thp_pkg::CFG_PRESS_HIGH: r_cfg_phi  <= i_cfg_wdata[15:0];
                thp_pkg::CFG_HUM:        r_cfg_hum  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3;
    logic signed [15:0] w_h2;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_cfg_temp[15:0];
    assign w_t2 = r_cfg_temp[31:16];
    assign w_t3 = r_cfg_temp[47:32];
    assign w_p1 = r_cfg_plo[15:0];
    assign w_p2 = r_cfg_plo[31:16];
    assign w_p3 = r_cfg_plo[47:32];
    assign w_p4 = r_cfg_plo[63:48];
    assign w_p5 = r_cfg_pmid[15:0];
    assign w_p6 = r_cfg_pmid[31:16];
    assign w_p7 = r_cfg_pmid[47:32];
    assign w_p8 = r_cfg_pmid[63:48];
    assign w_p9 = r_cfg_phi;
    assign w_h1 = r_cfg_hum[7:0];
    assign w_h2 = r_cfg_hum[23:8];
    assign w_h3 = r_cfg_hum[31:24];
    assign w_h4 = r_cfg_hum[43:32];
    assign w_h5 = r_cfg_hum[55:44];
    assign w_h6 = r_cfg_hum[63:56];

    // pipeline control
    logic        w_adv;
    logic [15:0] r_vld;
    logic [3:0]  r_dv;
    logic        r_out_valid;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_valid;

    // stage 1
    logic signed [17:0] w_s1_a, r_s1_a;
    logic signed [16:0] w_s1_b, r_s1_b;
    logic [31:0]        w_s1_lb, r_s1_lb;
    logic [20:0]        w_s1_pp, r_s1_pp;

    assign w_s1_a  = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_s1_b  = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, w_t1});
    assign w_s1_lb = {2'b00, i_raw_humidity, 14'd0} - {w_h4, 20'd0} + 32'd16384;
    assign w_s1_pp = thp_pkg::PRESS_RAW_TOP - {1'b0, i_raw_pressure};

    // stage 2
    logic signed [33:0] w_s2_m1, w_s2_bb;
    logic signed [31:0] r_s2_m1, r_s2_bb;
    logic [31:0]        r_s2_lb;
    logic [20:0]        r_s2_pp;

    assign w_s2_m1 = r_s1_a * w_t2;
    assign w_s2_bb = r_s1_b * r_s1_b;

    // stage 3
    logic signed [31:0] w_s3_v1, w_s3_bbs;
    logic signed [47:0] w_s3_m2;
    logic signed [31:0] r_s3_v1, r_s3_m2;
    logic [31:0]        r_s3_lb;
    logic [20:0]        r_s3_pp;

    assign w_s3_v1  = r_s2_m1 >>> 11;
    assign w_s3_bbs = r_s2_bb >>> 12;
    assign w_s3_m2  = w_s3_bbs * w_t3;

    // stage 4
    logic signed [31:0] w_s4_v2, r_s4_tf;
    logic [31:0]        r_s4_lb;
    logic [20:0]        r_s4_pp;

    assign w_s4_v2 = r_s3_m2 >>> 14;

    // stage 5
    logic signed [31:0] w_s5_t5, w_s5_temp;
    logic signed [32:0] w_s5_w1;
    logic signed [31:0] r_s5_temp;
    logic signed [32:0] r_s5_w1;
    logic [31:0]        r_s5_x, r_s5_lb;
    logic [20:0]        r_s5_pp;

    assign w_s5_t5   = (r_s4_tf <<< 2) + r_s4_tf + 32'sd128;
    assign w_s5_temp = w_s5_t5 >>> 8;
    assign w_s5_w1   = {r_s4_tf[31], r_s4_tf} - thp_pkg::TF_PRESS_OFS;

    // stage 6
    logic signed [65:0] w_s6_sq;
    logic signed [48:0] w_s6_p5, w_s6_p2;
    logic [31:0]        w_s6_hx, w_s6_xh3, w_s6_xh6;
    logic signed [63:0] r_s6_w1sq, r_s6_w1p5, r_s6_w1p2;
    logic [31:0]        r_s6_hx, r_s6_xh3, r_s6_xh6, r_s6_lb;
    logic signed [31:0] r_s6_temp;
    logic [20:0]        r_s6_pp;

    assign w_s6_sq  = r_s5_w1 * r_s5_w1;
    assign w_s6_p5  = r_s5_w1 * w_p5;
    assign w_s6_p2  = r_s5_w1 * w_p2;
    assign w_s6_hx  = r_s5_x * {{20{w_h5[11]}}, w_h5};
    assign w_s6_xh3 = r_s5_x * {24'd0, w_h3};
    assign w_s6_xh6 = r_s5_x * {{24{w_h6[7]}}, w_h6};

    // stage 7
    logic signed [79:0] w_s7_w2a, w_s7_w1c;
    logic signed [31:0] w_s7_ld, w_s7_xh3, w_s7_xh6;
    logic signed [31:0] w_s7_left, w_s7_inner, w_s7_t6;
    logic signed [63:0] r_s7_w2a, r_s7_w1c, r_s7_w1p5, r_s7_w1p2;
    logic signed [31:0] r_s7_left, r_s7_inner, r_s7_t6, r_s7_temp;
    logic [20:0]        r_s7_pp;

    assign w_s7_w2a   = r_s6_w1sq * w_p6;
    assign w_s7_w1c   = r_s6_w1sq * w_p3;
    assign w_s7_ld    = r_s6_lb - r_s6_hx;
    assign w_s7_xh3   = r_s6_xh3;
    assign w_s7_xh6   = r_s6_xh6;
    assign w_s7_left  = w_s7_ld >>> 15;
    assign w_s7_inner = (w_s7_xh3 >>> 11) + 32'sd32768;
    assign w_s7_t6    = w_s7_xh6 >>> 10;

    // stage 8
    logic signed [63:0] w_s8_w1cs, w_s8_w2, w_s8_w1n;
    logic [63:0]        w_s8_p4;
    logic [31:0]        w_s8_r0;
    logic signed [63:0] r_s8_w2, r_s8_w1n;
    logic signed [31:0] r_s8_left, r_s8_r0, r_s8_temp;
    logic [20:0]        r_s8_pp;

    assign w_s8_p4   = {{48{w_p4[15]}}, w_p4} << 35;
    assign w_s8_w1cs = r_s7_w1c >>> 8;
    assign w_s8_w2   = r_s7_w2a + (r_s7_w1p5 <<< 17) + $signed(w_s8_p4);
    assign w_s8_w1n  = w_s8_w1cs + (r_s7_w1p2 <<< 12);
    assign w_s8_r0   = r_s7_t6 * r_s7_inner;

    // stage 9
    logic signed [31:0] w_s9_r0s, w_s9_right;
    logic [63:0]        r_s9_w1s, r_s9_d;
    logic signed [31:0] r_s9_left, r_s9_right, r_s9_temp;

    assign w_s9_r0s   = r_s8_r0 >>> 10;
    assign w_s9_right = w_s9_r0s + 32'sd2097152;

    // stage 10
    logic [79:0]        w_s10_w1m;
    logic [75:0]        w_s10_num;
    logic [31:0]        w_s10_rh2;
    logic [63:0]        r_s10_w1m, r_s10_num;
    logic signed [31:0] r_s10_left, r_s10_rh2, r_s10_temp;

    assign w_s10_w1m = r_s9_w1s * w_p1;
    assign w_s10_num = r_s9_d * thp_pkg::PRESS_SCALE;
    assign w_s10_rh2 = r_s9_right * {{16{w_h2[15]}}, w_h2};

    // stage 11
    logic signed [63:0] w_s11_w1m;
    logic signed [31:0] w_s11_rs;
    logic [63:0]        r_s11_w1f, r_s11_num;
    logic signed [31:0] r_s11_left, r_s11_right, r_s11_temp;

    assign w_s11_w1m = r_s10_w1m;
    assign w_s11_rs  = r_s10_rh2 + 32'sd8192;

    // stage 12
    t_press_div         w_s12_pd;
    logic [31:0]        w_s12_xx;
    t_press_div         r_s12_pd, r_s13_pd, r_s14_pd, r_s15_pd, r_s16_pd;
    logic signed [31:0] r_s12_xx, r_s12_temp;

    assign w_s12_pd.an   = r_s11_num[63] ? 64'd0 - r_s11_num : r_s11_num;
    assign w_s12_pd.ad   = r_s11_w1f[63] ? 64'd0 - r_s11_w1f : r_s11_w1f;
    assign w_s12_pd.neg  = r_s11_num[63] ^ r_s11_w1f[63];
    assign w_s12_pd.zero = (r_s11_w1f == 64'd0);
    assign w_s12_xx      = r_s11_left * r_s11_right;

    // stages 13 to 16, humidity tail; divider operands and temperature ride along
    logic signed [31:0] r_s13_xx, r_s13_s, r_s13_temp;
    logic [31:0]        w_s14_ss;
    logic signed [31:0] r_s14_xx, r_s14_ss, r_s14_temp;
    logic signed [31:0] w_s15_sss;
    logic [31:0]        w_s15_y;
    logic signed [31:0] r_s15_xx, r_s15_y, r_s15_temp;
    logic signed [31:0] w_s16_xv;
    logic [31:0]        w_s16_cl;
    logic [16:0]        r_s16_hum;
    logic signed [31:0] r_s16_temp;

    assign w_s14_ss  = r_s13_s * r_s13_s;
    assign w_s15_sss = r_s14_ss >>> 7;
    assign w_s15_y   = w_s15_sss * {24'd0, w_h1};
    assign w_s16_xv  = r_s15_xx - (r_s15_y >>> 4);

    always_comb begin
        if (w_s16_xv[31]) begin
            w_s16_cl = '0;
        end else if (w_s16_xv > thp_pkg::HUM_CLAMP) begin
            w_s16_cl = thp_pkg::HUM_CLAMP;
        end else begin
            w_s16_cl = w_s16_xv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_a     <= w_s1_a;
            r_s1_b     <= w_s1_b;
            r_s1_lb    <= w_s1_lb;
            r_s1_pp    <= w_s1_pp;

            r_s2_m1    <= w_s2_m1[31:0];
            r_s2_bb    <= w_s2_bb[31:0];
            r_s2_lb    <= r_s1_lb;
            r_s2_pp    <= r_s1_pp;

            r_s3_v1    <= w_s3_v1;
            r_s3_m2    <= w_s3_m2[31:0];
            r_s3_lb    <= r_s2_lb;
            r_s3_pp    <= r_s2_pp;

            r_s4_tf    <= r_s3_v1 + w_s4_v2;
            r_s4_lb    <= r_s3_lb;
            r_s4_pp    <= r_s3_pp;

            r_s5_temp  <= w_s5_temp;
            r_s5_w1    <= w_s5_w1;
            r_s5_x     <= r_s4_tf - thp_pkg::TF_HUM_OFS;
            r_s5_lb    <= r_s4_lb;
            r_s5_pp    <= r_s4_pp;

            r_s6_w1sq  <= w_s6_sq[63:0];
            r_s6_w1p5  <= {{15{w_s6_p5[48]}}, w_s6_p5};
            r_s6_w1p2  <= {{15{w_s6_p2[48]}}, w_s6_p2};
            r_s6_hx    <= w_s6_hx;
            r_s6_xh3   <= w_s6_xh3;
            r_s6_xh6   <= w_s6_xh6;
            r_s6_lb    <= r_s5_lb;
            r_s6_temp  <= r_s5_temp;
            r_s6_pp    <= r_s5_pp;

            r_s7_w2a   <= w_s7_w2a[63:0];
            r_s7_w1c   <= w_s7_w1c[63:0];
            r_s7_w1p5  <= r_s6_w1p5;
            r_s7_w1p2  <= r_s6_w1p2;
            r_s7_left  <= w_s7_left;
            r_s7_inner <= w_s7_inner;
            r_s7_t6    <= w_s7_t6;
            r_s7_temp  <= r_s6_temp;
            r_s7_pp    <= r_s6_pp;

            r_s8_w2    <= w_s8_w2;
            r_s8_w1n   <= w_s8_w1n;
            r_s8_left  <= r_s7_left;
            r_s8_r0    <= w_s8_r0;
            r_s8_temp  <= r_s7_temp;
            r_s8_pp    <= r_s7_pp;

            r_s9_w1s   <= r_s8_w1n + thp_pkg::PRESS_BIAS;
            r_s9_d     <= ({43'd0, r_s8_pp} << 31) - r_s8_w2;
            r_s9_left  <= r_s8_left;
            r_s9_right <= w_s9_right;
            r_s9_temp  <= r_s8_temp;

            r_s10_w1m  <= w_s10_w1m[63:0];
            r_s10_num  <= w_s10_num[63:0];
            r_s10_left <= r_s9_left;
            r_s10_rh2  <= w_s10_rh2;
            r_s10_temp <= r_s9_temp;

            r_s11_w1f   <= w_s11_w1m >>> 33;
            r_s11_num   <= r_s10_num;
            r_s11_left  <= r_s10_left;
            r_s11_right <= w_s11_rs >>> 14;
            r_s11_temp  <= r_s10_temp;

            r_s12_pd   <= w_s12_pd;
            r_s12_xx   <= w_s12_xx;
            r_s12_temp <= r_s11_temp;

            r_s13_pd   <= r_s12_pd;
            r_s13_xx   <= r_s12_xx;
            r_s13_s    <= r_s12_xx >>> 15;
            r_s13_temp <= r_s12_temp;

            r_s14_pd   <= r_s13_pd;
            r_s14_xx   <= r_s13_xx;
            r_s14_ss   <= w_s14_ss;
            r_s14_temp <= r_s13_temp;

            r_s15_pd   <= r_s14_pd;
            r_s15_xx   <= r_s14_xx;
            r_s15_y    <= w_s15_y;
            r_s15_temp <= r_s14_temp;

            r_s16_pd   <= r_s15_pd;
            r_s16_hum  <= w_s16_cl[28:12];
            r_s16_temp <= r_s15_temp;
        end
    end

    // divider
    thp_pkg::t_div_side w_div_side, w_dq_side;
    logic               w_dq_valid;
    logic [63:0]        w_dq;

    assign w_div_side.temp = r_s16_temp;
    assign w_div_side.hum  = r_s16_hum;
    assign w_div_side.neg  = r_s16_pd.neg;
    assign w_div_side.zero = r_s16_pd.zero;

    thp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_vld[15]),
        .i_num   (r_s16_pd.an),
        .i_den   (r_s16_pd.ad),
        .i_side  (w_div_side),
        .o_valid (w_dq_valid),
        .o_quo   (w_dq),
        .o_side  (w_dq_side)
    );

    // post divide stages
    logic signed [63:0] r_d1_p;
    thp_pkg::t_div_side r_d1_side, r_d2_side, r_d3_side, r_d4_side;
    logic signed [63:0] w_d2_ps;
    logic signed [79:0] w_d2_m9, w_d2_m8;
    logic signed [63:0] r_d2_p, r_d2_ps, r_d2_m9, r_d2_m8;
    logic [63:0]        w_d3_ll;
    logic [31:0]        w_d3_c1, w_d3_c2;
    logic [63:0]        r_d3_ll;
    logic [31:0]        r_d3_c1, r_d3_c2;
    logic signed [63:0] r_d3_m8, r_d3_p;
    logic signed [63:0] w_d4_prod;
    logic signed [63:0] r_d4_x1, r_d4_x2, r_d4_p;
    logic signed [63:0] w_o_sum, w_o_p7, w_o_pres;

    assign w_d2_ps   = r_d1_p >>> 13;
    assign w_d2_m9   = w_p9 * w_d2_ps;
    assign w_d2_m8   = w_p8 * r_d1_p;
    assign w_d3_ll   = r_d2_m9[31:0] * r_d2_ps[31:0];
    assign w_d3_c1   = r_d2_m9[31:0] * r_d2_ps[63:32];
    assign w_d3_c2   = r_d2_m9[63:32] * r_d2_ps[31:0];
    assign w_d4_prod = r_d3_ll + {r_d3_c1 + r_d3_c2, 32'd0};
    assign w_o_sum   = r_d4_p + r_d4_x1 + r_d4_x2;
    assign w_o_p7    = {{48{w_p7[15]}}, w_p7} << 4;
    assign w_o_pres  = (w_o_sum >>> 8) + w_o_p7;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1_p    <= w_dq_side.neg ? 64'd0 - w_dq : w_dq;
            r_d1_side <= w_dq_side;

            r_d2_p    <= r_d1_p;
            r_d2_ps   <= w_d2_ps;
            r_d2_m9   <= w_d2_m9[63:0];
            r_d2_m8   <= w_d2_m8[63:0];
            r_d2_side <= r_d1_side;

            r_d3_ll   <= w_d3_ll;
            r_d3_c1   <= w_d3_c1;
            r_d3_c2   <= w_d3_c2;
            r_d3_m8   <= r_d2_m8;
            r_d3_p    <= r_d2_p;
            r_d3_side <= r_d2_side;

            r_d4_x1   <= w_d4_prod >>> 25;
            r_d4_x2   <= r_d3_m8 >>> 19;
            r_d4_p    <= r_d3_p;
            r_d4_side <= r_d3_side;

            o_temperature_centi <= r_d4_side.temp;
            o_humidity_q22_10   <= r_d4_side.hum;
            o_pressure_q24_8    <= r_d4_side.zero ? 32'd0 : w_o_pres[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_dv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[14:0], i_valid};
            r_dv        <= {r_dv[2:0], w_dq_valid};
            r_out_valid <= r_dv[3];
        end
    end

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_humidity_q22_10 <= thp_pkg::HUM_OUT_MAX))
        else $error("humidity result above clamp");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[3] && w_adv && r_d4_side.zero) |=> (o_pressure_q24_8 == 32'd0))
        else $error("zero divisor did not give zero pressure");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0 && r_dv == '0))
        else $error("valid bits not cleared by reset");

endmodule
